// ----- rtl/core/pinned_priority_heapsort_queue_defines.svh -----
// Assertion macros for the pinned priority heapsort queue.
// Defining NO_ASSERTIONS removes every check.
`ifndef PINNED_PRIORITY_HEAPSORT_QUEUE_DEFINES_SVH
`define PINNED_PRIORITY_HEAPSORT_QUEUE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define PPHQ_ASSERT_IMP(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("check failed");
`define PPHQ_ASSERT_NXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("check failed");
`else
`define PPHQ_ASSERT_IMP(label, clk, rst_n, a, c)
`define PPHQ_ASSERT_NXT(label, clk, rst_n, a, c)
`endif
`endif

// ----- rtl/core/pphq_pkg.sv -----
// Shared types and codes of the pinned priority heapsort queue.
// No dependencies.
package pphq_pkg;
	localparam logic [2:0] ACT_INSERT  = 3'd0;
	localparam logic [2:0] ACT_MARK    = 3'd1;
	localparam logic [2:0] ACT_CANCEL  = 3'd2;
	localparam logic [2:0] ACT_SORT    = 3'd3;
	localparam logic [2:0] ACT_EXTRACT = 3'd4;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_FULL     = 2'd1;
	localparam logic [1:0] ST_EMPTY    = 2'd2;
	localparam logic [1:0] ST_NOTFOUND = 2'd3;

	typedef struct packed {
		logic [31:0] tag;
		logic [15:0] key;
		logic [63:0] coord;
		logic        pin;
	} entry_t;
endpackage

// ----- rtl/core/pphq_store.sv -----
// Entry memory of the queue: one write port and one registered read port.
// Depends on pphq_pkg.
module pphq_store #(
	parameter int AW = 6
) (
	input  logic            clk,
	input  logic            we,
	input  logic [AW-1:0]   waddr,
	input  pphq_pkg::entry_t wdata,
	input  logic [AW-1:0]   raddr,
	output pphq_pkg::entry_t rdata
);
	import pphq_pkg::*;
	entry_t mem [2**AW];
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// ----- rtl/core/pinned_priority_heapsort_queue.sv -----
// Top level of the pinned priority heapsort queue: sequencer over one entry memory.
// Depends on pphq_pkg, pphq_store and the assertion macro header.
//
// Channel | Direction | Handshake        | Payload
// in      | input     | in_valid/ready   | action, customer_tag, rating_key, coordinates
// out     | output    | out_valid/ready  | status, extracted entry, entries_held
//
// Insert goes straight to its result; mark reads the last entry and writes it back pinned,
// extract reads the last entry into the output register, and cancel reads and checks
// entries in turn, then moves the last entry into the freed slot. Every sift level of sort
// reads, compares and writes the entry memory one entry per cycle.
// Reset clears the count, the sequencer and the output valid flag only; the memory holds no reset value.
// The block accepts an item only when idle and its output register is empty.
`include "pinned_priority_heapsort_queue_defines.svh"
module pinned_priority_heapsort_queue #(
	parameter int CAPACITY = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  action,
	input  logic [31:0] customer_tag,
	input  logic [15:0] rating_key,
	input  logic signed [15:0] origin_x,
	input  logic signed [15:0] origin_y,
	input  logic signed [15:0] target_x,
	input  logic signed [15:0] target_y,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [31:0] out_tag,
	output logic [15:0] out_key,
	output logic signed [15:0] out_origin_x,
	output logic signed [15:0] out_origin_y,
	output logic signed [15:0] out_target_x,
	output logic signed [15:0] out_target_y,
	output logic        out_pinned,
	output logic [6:0]  entries_held
);
	import pphq_pkg::*;
	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int XW = AW + 2;

	localparam logic [4:0] S_IDLE   = 5'd0;
	localparam logic [4:0] S_EXRD   = 5'd1;
	localparam logic [4:0] S_EXWT   = 5'd2;
	localparam logic [4:0] S_MKRD   = 5'd3;
	localparam logic [4:0] S_MKWT   = 5'd4;
	localparam logic [4:0] S_CNRD   = 5'd5;
	localparam logic [4:0] S_CNCK   = 5'd6;
	localparam logic [4:0] S_CNLW   = 5'd7;
	localparam logic [4:0] S_CNLC   = 5'd8;
	localparam logic [4:0] S_SIFT   = 5'd9;
	localparam logic [4:0] S_SKW    = 5'd10;
	localparam logic [4:0] S_SLW    = 5'd11;
	localparam logic [4:0] S_SRW    = 5'd12;
	localparam logic [4:0] S_SRC    = 5'd13;
	localparam logic [4:0] S_SWW    = 5'd14;
	localparam logic [4:0] S_SDONE  = 5'd15;
	localparam logic [4:0] S_PINRD  = 5'd16;
	localparam logic [4:0] S_PINCK  = 5'd17;
	localparam logic [4:0] S_XARD   = 5'd18;
	localparam logic [4:0] S_XAW    = 5'd19;
	localparam logic [4:0] S_XBW    = 5'd20;
	localparam logic [4:0] S_XBC    = 5'd21;
	localparam logic [4:0] S_OUT    = 5'd22;

	localparam logic [1:0] PH_BUILD1 = 2'd0;
	localparam logic [1:0] PH_BUILD2 = 2'd1;
	localparam logic [1:0] PH_SORT   = 2'd2;

	logic [4:0]    state_q;
	logic [CW-1:0] count_q, n_q, i_q;
	logic [XW-1:0] k_q, big_q, kb_q, root_q;
	logic [1:0]    phase_q;
	logic [31:0]   tag_q;
	entry_t        ek_q, el_q, eb_q, ex_q;
	logic          after_x_q;
	logic [4:0]    ret_q;

	logic          we;
	logic [AW-1:0] waddr, raddr;
	entry_t        wdata, rdata;

	logic          ov_q;
	logic [1:0]    st_q;
	entry_t        oe_q;

	pphq_store #(.AW(AW)) u_store (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	logic [XW-1:0] left_c, right_c;
	assign left_c  = XW'({k_q, 1'b0}) + XW'(1);
	assign right_c = left_c + XW'(1);

	// Combinational memory control from the sequencer state.
	always_comb begin
		we    = 1'b0;
		waddr = '0;
		wdata = '0;
		raddr = '0;
		unique case (state_q)
			S_IDLE: begin
				we    = in_valid && in_ready && action == ACT_INSERT &&
					count_q < CW'(CAPACITY);
				waddr = AW'(count_q);
				wdata = '{tag: customer_tag, key: rating_key,
					coord: {target_y, target_x, origin_y, origin_x}, pin: 1'b0};
			end
			S_EXRD, S_MKRD: raddr = AW'(count_q - CW'(1));
			S_MKWT: begin
				we    = 1'b1;
				waddr = AW'(count_q - CW'(1));
				wdata = '{tag: rdata.tag, key: rdata.key, coord: rdata.coord, pin: 1'b1};
			end
			S_CNRD, S_PINRD: raddr = AW'(i_q);
			S_CNLW: raddr = AW'(count_q - CW'(1));
			S_CNLC: begin
				we    = 1'b1;
				waddr = AW'(i_q);
				wdata = rdata;
			end
			S_SIFT:  raddr = AW'(k_q);
			S_SKW:   raddr = AW'(left_c);
			S_SLW:   raddr = AW'(right_c);
			S_SWW: begin
				we    = 1'b1;
				waddr = AW'(k_q);
				wdata = eb_q;
			end
			S_SDONE: begin
				we    = big_q != k_q;
				waddr = AW'(big_q);
				wdata = ek_q;
			end
			S_XARD: raddr = AW'(kb_q);
			S_XAW:  raddr = AW'(n_q - CW'(1));
			S_XBW: begin
				we    = 1'b1;
				waddr = AW'(kb_q);
				wdata = rdata;
			end
			S_XBC: begin
				we    = 1'b1;
				waddr = AW'(n_q - CW'(1));
				wdata = ex_q;
			end
			default: ;
		endcase
	end

	assign in_ready = state_q == S_IDLE && !ov_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			ov_q      <= 1'b0;
			phase_q   <= PH_BUILD1;
			after_x_q <= 1'b0;
			ret_q     <= S_IDLE;
		end else begin
			if (ov_q && out_ready) ov_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (in_valid && in_ready) begin
					tag_q <= customer_tag;
					oe_q  <= '0;
					i_q   <= '0;
					if (action == ACT_INSERT) begin
						if (count_q < CW'(CAPACITY)) begin
							count_q <= count_q + CW'(1);
							st_q    <= ST_OK;
						end else st_q <= ST_FULL;
						state_q <= S_OUT;
					end else if (action > ACT_EXTRACT) begin
						st_q    <= ST_OK;
						state_q <= S_OUT;
					end else if (count_q == '0) begin
						st_q    <= ST_EMPTY;
						state_q <= S_OUT;
					end else begin
						st_q <= ST_OK;
						unique case (action)
							ACT_MARK:    state_q <= S_MKRD;
							ACT_CANCEL:  state_q <= S_CNRD;
							ACT_EXTRACT: state_q <= S_EXRD;
							default: begin
								n_q     <= count_q;
								phase_q <= PH_BUILD1;
								root_q  <= XW'(count_q >> 1) + XW'(1);
								k_q     <= XW'(count_q >> 1) + XW'(1);
								big_q   <= XW'(count_q >> 1) + XW'(1);
								state_q <= S_SDONE;
								ret_q   <= S_SIFT;
							end
						endcase
					end
				end
				S_EXRD: state_q <= S_EXWT;
				S_EXWT: begin
					oe_q    <= rdata;
					count_q <= count_q - CW'(1);
					state_q <= S_OUT;
				end
				S_MKRD: state_q <= S_MKWT;
				S_MKWT: state_q <= S_OUT;
				S_CNRD: state_q <= S_CNCK;
				S_CNCK: begin
					if (rdata.tag == tag_q) state_q <= S_CNLW;
					else if (i_q + CW'(1) >= count_q) begin
						st_q    <= ST_NOTFOUND;
						state_q <= S_OUT;
					end else begin
						i_q     <= i_q + CW'(1);
						state_q <= S_CNRD;
					end
				end
				S_CNLW: state_q <= S_CNLC;
				S_CNLC: begin
					count_q <= count_q - CW'(1);
					state_q <= S_OUT;
				end
				// Sift-down: read k, left, right; compare; swap via two writes.
				S_SIFT: begin
					if (left_c >= XW'(n_q)) state_q <= S_SDONE;
					else state_q <= S_SKW;
				end
				S_SKW: begin
					ek_q    <= rdata;
					state_q <= S_SLW;
				end
				S_SLW: begin
					el_q    <= rdata;
					state_q <= S_SRW;
				end
				S_SRW: begin
					if (right_c < XW'(n_q) && el_q.key < rdata.key) begin
						eb_q  <= rdata;
						big_q <= right_c;
					end else begin
						eb_q  <= el_q;
						big_q <= left_c;
					end
					state_q <= S_SRC;
				end
				S_SRC: begin
					if (ek_q.key < eb_q.key) state_q <= S_SWW;
					else begin
						big_q   <= k_q;
						state_q <= S_SDONE;
					end
				end
				S_SWW: state_q <= S_SDONE;
				S_SDONE: begin
					if (big_q != k_q && ret_q == S_SIFT && state_q == S_SDONE &&
						big_q != '0 && ek_q.key < eb_q.key) begin
						k_q     <= big_q;
						state_q <= S_SIFT;
					end else begin
						// One sift-down finished: choose the next step.
						if (phase_q != PH_SORT && root_q != '0) begin
							root_q  <= root_q - XW'(1);
							k_q     <= root_q - XW'(1);
							big_q   <= root_q - XW'(1);
							state_q <= S_SIFT;
						end else begin
							big_q <= '0;
							k_q   <= '0;
							if (phase_q == PH_BUILD1) begin
								i_q     <= '0;
								state_q <= S_PINRD;
							end else if (n_q >= CW'(1)) begin
								phase_q   <= PH_SORT;
								kb_q      <= '0;
								after_x_q <= 1'b0;
								state_q   <= S_XARD;
							end else state_q <= S_OUT;
						end
					end
				end
				S_PINRD: state_q <= S_PINCK;
				S_PINCK: begin
					if (rdata.pin) begin
						kb_q      <= XW'(i_q);
						after_x_q <= 1'b1;
						state_q   <= S_XARD;
					end else if (i_q + CW'(1) >= n_q) begin
						phase_q <= PH_SORT;
						kb_q    <= '0;
						state_q <= (n_q >= CW'(1)) ? S_XARD : S_OUT;
					end else begin
						i_q     <= i_q + CW'(1);
						state_q <= S_PINRD;
					end
				end
				S_XARD: state_q <= S_XAW;
				S_XAW: begin
					ex_q    <= rdata;
					state_q <= S_XBW;
				end
				S_XBW: state_q <= S_XBC;
				S_XBC: begin
					n_q <= n_q - CW'(1);
					if (after_x_q) begin
						after_x_q <= 1'b0;
						phase_q   <= PH_BUILD2;
						root_q    <= XW'((n_q - CW'(1)) >> 1) + XW'(1);
						k_q       <= XW'((n_q - CW'(1)) >> 1) + XW'(1);
						big_q     <= XW'((n_q - CW'(1)) >> 1) + XW'(1);
						state_q   <= S_SDONE;
					end else begin
						k_q     <= '0;
						big_q   <= '0;
						state_q <= S_SIFT;
					end
				end
				S_OUT: begin
					ov_q    <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid    = ov_q;
	assign status       = st_q;
	assign out_tag      = oe_q.tag;
	assign out_key      = oe_q.key;
	assign out_origin_x = oe_q.coord[15:0];
	assign out_origin_y = oe_q.coord[31:16];
	assign out_target_x = oe_q.coord[47:32];
	assign out_target_y = oe_q.coord[63:48];
	assign out_pinned   = oe_q.pin;
	assign entries_held = 7'(count_q);

	`PPHQ_ASSERT_IMP(a_count_bound, clk, arst_n, 1'b1, count_q <= CW'(CAPACITY))
	`PPHQ_ASSERT_IMP(a_busy_no_ready, clk, arst_n, state_q != S_IDLE, !in_ready)
	`PPHQ_ASSERT_NXT(a_out_hold, clk, arst_n, ov_q && !out_ready, ov_q && $stable(st_q))
	`PPHQ_ASSERT_NXT(a_accept_busy, clk, arst_n, in_valid && in_ready, state_q != S_IDLE)
endmodule

// ----- bench/tb.sv -----
// Self-checking testbench for the pinned priority heapsort queue.
// Depends on pphq_pkg and the pinned_priority_heapsort_queue top level.
// A request table predictor in a scoreboard class checks every result transfer.
`timescale 1ns / 100ps
module tb;
	import pphq_pkg::*;

	localparam int DEPTH = 64;
	localparam int MAX_CYCLES = 4000000;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] tag;
		logic [15:0] key;
		logic [15:0] ox;
		logic [15:0] oy;
		logic [15:0] tx;
		logic [15:0] ty;
		logic        pin;
		logic [6:0]  held;
	} reply_t;

	class table_scoreboard;
		entry_t rows[DEPTH];
		int held;
		reply_t pending[$];
		int mismatches;

		function void swap_rows(int a, int b);
			entry_t t;
			t = rows[a];
			rows[a] = rows[b];
			rows[b] = t;
		endfunction

		function void sift(int n, int k);
			int l;
			int big;
			forever begin
				l = 2 * k + 1;
				if (l >= n) return;
				big = l;
				if (l + 1 < n && rows[l].key < rows[l + 1].key) big = l + 1;
				if (!(rows[k].key < rows[big].key)) return;
				swap_rows(k, big);
				k = big;
			end
		endfunction

		function void heapify(int n);
			for (int k = n / 2; k >= 0; k--) sift(n, k);
		endfunction

		function void sort_rows();
			int n;
			int i;
			n = held;
			heapify(n);
			for (i = 0; i < n; i++) if (rows[i].pin) break;
			if (i < n) begin
				swap_rows(i, n - 1);
				n--;
				heapify(n);
			end
			while (n >= 1) begin
				swap_rows(0, n - 1);
				n--;
				sift(n, 0);
			end
		endfunction

		function void note_request(logic [2:0] act, logic [31:0] tag, logic [15:0] key,
				logic [63:0] coord);
			reply_t r;
			int i;
			r = '0;
			r.status = ST_OK;
			if (act == ACT_INSERT) begin
				if (held >= DEPTH) r.status = ST_FULL;
				else begin
					rows[held] = '{tag: tag, key: key, coord: coord, pin: 1'b0};
					held++;
				end
			end else if (act <= ACT_EXTRACT && held == 0) begin
				r.status = ST_EMPTY;
			end else if (act == ACT_MARK) begin
				rows[held - 1].pin = 1'b1;
			end else if (act == ACT_CANCEL) begin
				for (i = 0; i < held; i++) if (rows[i].tag == tag) break;
				if (i >= held) r.status = ST_NOTFOUND;
				else begin
					swap_rows(i, held - 1);
					held--;
				end
			end else if (act == ACT_SORT) begin
				sort_rows();
			end else if (act == ACT_EXTRACT) begin
				r.tag = rows[held - 1].tag;
				r.key = rows[held - 1].key;
				{r.ty, r.tx, r.oy, r.ox} = rows[held - 1].coord;
				r.pin = rows[held - 1].pin;
				held--;
			end
			r.held = held[6:0];
			pending.push_back(r);
		endfunction

		function void check_reply(reply_t got);
			reply_t want;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("Unexpected result transfer: %p", got);
				return;
			end
			want = pending.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10) $display("Mismatch: expected %p, got %p", want, got);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [2:0] action = '0;
	logic [31:0] customer_tag = '0;
	logic [15:0] rating_key = '0;
	logic signed [15:0] origin_x = '0, origin_y = '0, target_x = '0, target_y = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [1:0] status;
	logic [31:0] out_tag;
	logic [15:0] out_key;
	logic signed [15:0] out_origin_x, out_origin_y, out_target_x, out_target_y;
	logic out_pinned;
	logic [6:0] entries_held;

	table_scoreboard board = new();
	int cycles = 0;
	int wait_left = 0;
	bit took = 1'b0;
	bit stall_go = 1'b0;
	bit stall_done = 1'b0;
	bit sending_done = 1'b0;
	logic [31:0] used_tags[$];

	pinned_priority_heapsort_queue u_top (.*);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > MAX_CYCLES) begin
			$display("[pinned_priority_heapsort_queue] ERROR");
			$finish;
		end
	end

	always @(posedge clk) begin
		took <= out_valid && out_ready;
		if (out_valid && out_ready)
			board.check_reply({status, out_tag, out_key, out_origin_x, out_origin_y,
				out_target_x, out_target_y, out_pinned, entries_held});
	end

	always @(negedge clk) begin
		int draw;
		draw = $urandom_range(0, 19);
		if (stall_go && !stall_done) begin
			stall_done <= 1'b1;
			wait_left  <= 400;
			out_ready  <= 1'b0;
		end else if (took) begin
			wait_left <= draw;
			out_ready <= (draw == 0);
		end else if (wait_left > 0) begin
			wait_left <= wait_left - 1;
			out_ready <= (wait_left == 1);
		end else begin
			out_ready <= 1'b1;
		end
	end

	task automatic send(logic [2:0] act, logic [31:0] tag, logic [15:0] key,
			logic [63:0] coord, bit no_gap = 0);
		int gap;
		gap = no_gap ? 0 : (($urandom_range(0, 2) == 0) ? $urandom_range(0, 19) : 0);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		action <= act;
		customer_tag <= tag;
		rating_key <= key;
		{target_y, target_x, origin_y, origin_x} <= coord;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		board.note_request(act, tag, key, coord);
		if (act == ACT_INSERT) used_tags.push_back(tag);
		@(negedge clk);
	endtask

	function automatic logic [63:0] rand_coord();
		return {$urandom(), $urandom()};
	endfunction

	task automatic random_item();
		int pick;
		logic [31:0] tag;
		logic [15:0] key;
		pick = $urandom_range(0, 99);
		key = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 7)) : 16'($urandom());
		tag = ($urandom_range(0, 3) == 0 && used_tags.size() > 0) ?
			used_tags[$urandom_range(0, used_tags.size() - 1)] : $urandom();
		if (pick < 45) send(ACT_INSERT, tag, key, rand_coord());
		else if (pick < 55) send(ACT_MARK, $urandom(), 16'($urandom()), rand_coord());
		else if (pick < 67) send(ACT_CANCEL, tag, 16'($urandom()), rand_coord());
		else if (pick < 74) send(ACT_SORT, $urandom(), 16'($urandom()), rand_coord());
		else if (pick < 97) send(ACT_EXTRACT, $urandom(), 16'($urandom()), rand_coord());
		else send(3'($urandom_range(5, 7)), $urandom(), 16'($urandom()), rand_coord());
	endtask

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send(ACT_MARK, 0, 0, 0);
		send(ACT_CANCEL, 32'hFFFF_FFFF, 0, 0);
		send(ACT_SORT, 0, 0, 0);
		send(ACT_EXTRACT, 0, 0, 0);
		send(3'd5, 0, 0, 0);
		send(3'd7, 32'hFFFF_FFFF, 16'hFFFF, '1);
		send(ACT_INSERT, 32'hFFFF_FFFF, 16'hFFFF, 64'h7FFF_8000_7FFF_8000);
		send(ACT_INSERT, 32'h0, 16'h0, 64'h8000_7FFF_8000_7FFF);
		send(ACT_INSERT, 32'h5, 16'h0100, 64'hFFFF_0000_FFFF_0001);
		send(ACT_INSERT, 32'h5, 16'h0100, rand_coord());
		send(ACT_MARK, 0, 0, 0);
		send(ACT_INSERT, 32'h7, 16'h0100, rand_coord());
		send(ACT_SORT, 0, 0, 0);
		send(ACT_CANCEL, 32'h5, 0, 0);
		send(ACT_CANCEL, 32'h1234, 0, 0);
		send(ACT_SORT, 0, 0, 0);
		send(ACT_EXTRACT, 0, 0, 0);
		send(ACT_EXTRACT, 0, 0, 0);
		send(ACT_EXTRACT, 0, 0, 0);
		send(ACT_EXTRACT, 0, 0, 0);

		// Fill the table past capacity while results back up behind a long stall.
		stall_go = 1'b1;
		for (int i = 0; i < DEPTH + 2; i++)
			send(ACT_INSERT, $urandom(), 16'($urandom()), rand_coord(), 1);
		send(ACT_MARK, 0, 0, 0);
		send(ACT_SORT, 0, 0, 0);
		for (int i = 0; i < 30; i++) send(ACT_EXTRACT, 0, 0, 0);

		for (int i = 0; i < 540; i++) random_item();
		while (board.held > 0) send(ACT_EXTRACT, 0, 0, 0);
		in_valid <= 1'b0;
		sending_done = 1'b1;
	end

	initial begin
		wait (sending_done);
		while (board.pending.size() > 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (board.mismatches == 0 && board.pending.size() == 0)
			$display("[pinned_priority_heapsort_queue] OK");
		else
			$display("[pinned_priority_heapsort_queue] ERROR");
		$finish;
	end
endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/pphq_pkg.sv
rtl/core/pphq_store.sv
rtl/core/pinned_priority_heapsort_queue.sv
bench/tb.sv
